FILE: hdl/assert_macros.svh
// Assertion macros shared by the receiver RTL.
// No dependencies; define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check that CONS holds whenever ANTE holds
`define CUSR_ASSERT_IMPLY(LBL, CLK, RSTN, ANTE, CONS) \
    LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |-> (CONS)) \
        else $error("implication check failed");
// Check that COND never holds
`define CUSR_ASSERT_NEVER(LBL, CLK, RSTN, COND) \
    LBL: assert property (@(posedge CLK) disable iff (!RSTN) !(COND)) \
        else $error("forbidden condition seen");
`else
`define CUSR_ASSERT_IMPLY(LBL, CLK, RSTN, ANTE, CONS)
`define CUSR_ASSERT_NEVER(LBL, CLK, RSTN, COND)
`endif
`endif

FILE: hdl/cusr_pkg.sv
// Shared types and codes of the chunked update session receiver.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package cusr_pkg;

    // Queue depth between front and back
    localparam int CUSR_QDEPTH = 2;

    // Reset value of the inactivity limit
    localparam logic [31:0] CUSR_TIMEOUT_RST = 32'd30000;

    // Register indexes of the configuration port
    localparam logic REG_NODE_ID = 1'b0;
    localparam logic REG_TIMEOUT = 1'b1;

    // Incoming message types
    localparam logic [2:0] REQ_START = 3'd0;
    localparam logic [2:0] REQ_CHUNK = 3'd1;
    localparam logic [2:0] REQ_END   = 3'd2;
    localparam logic [2:0] REQ_ABORT = 3'd3;
    localparam logic [2:0] REQ_TICK  = 3'd4;

    // Acknowledgement kinds
    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_CHUNK = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;

    // Acknowledgement status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_SIZE     = 3'd1;
    localparam logic [2:0] ST_SESSION  = 3'd2;
    localparam logic [2:0] ST_WRITE    = 3'd3;
    localparam logic [2:0] ST_CHECKSUM = 3'd4;

    // Classified operation handed from front to back
    typedef enum logic [2:0] {
        OP_NONE,
        OP_START,
        OP_CHUNK,
        OP_END,
        OP_ABORT,
        OP_TICK
    } t_op;

    // One classified request
    typedef struct packed {
        t_op         op;
        logic        mine;
        logic [15:0] session_id;
        logic [15:0] chunk_index;
        logic [15:0] total_chunks;
        logic [31:0] now_ms;
        logic        storage_ok;
    } t_item;

    // One result
    typedef struct packed {
        logic        ack_valid;
        logic [1:0]  ack_kind;
        logic [15:0] ack_session;
        logic [15:0] ack_chunk;
        logic [2:0]  ack_status;
        logic        discard_image;
        logic        reboot_request;
    } t_result;

endpackage

FILE: hdl/cusr_front.sv
// Front end: accepts requests, decodes the type and checks the target address.
// Depends on cusr_pkg.
`timescale 1ns / 1ps
module cusr_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [2:0]           i_req_type,
    input  logic [15:0]          i_target_id,
    input  logic [15:0]          i_session_id,
    input  logic [15:0]          i_chunk_index,
    input  logic [15:0]          i_total_chunks,
    input  logic [31:0]          i_now_ms,
    input  logic                 i_storage_ok,
    input  logic [15:0]          i_node_id,
    output logic                 o_item_valid,
    input  logic                 i_item_stall,
    output cusr_pkg::t_item      o_item
);
    import cusr_pkg::*;

    logic  r_valid;
    logic  n_valid;
    t_item r_item;
    t_item n_item;
    logic  w_take;

    // Hold the request while the queue is full
    assign o_stall = r_valid && i_item_stall;
    assign w_take  = i_valid && !o_stall;

    // Classify the request
    always_comb begin
        n_item.mine         = (i_target_id == i_node_id);
        n_item.session_id   = i_session_id;
        n_item.chunk_index  = i_chunk_index;
        n_item.total_chunks = i_total_chunks;
        n_item.now_ms       = i_now_ms;
        n_item.storage_ok   = i_storage_ok;
        unique case (i_req_type)
            REQ_START: n_item.op = OP_START;
            REQ_CHUNK: n_item.op = OP_CHUNK;
            REQ_END:   n_item.op = OP_END;
            REQ_ABORT: n_item.op = OP_ABORT;
            REQ_TICK:  n_item.op = OP_TICK;
            default:   n_item.op = OP_NONE;
        endcase
    end

    // Advance the stage
    assign n_valid = w_take || (r_valid && i_item_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item <= n_item;
        end
    end

    assign o_item_valid = r_valid;
    assign o_item       = r_item;

endmodule

FILE: hdl/cusr_queue.sv
// Small FIFO of classified requests between the front and back ends.
// Depends on cusr_pkg.
`timescale 1ns / 1ps
module cusr_queue #(
    parameter int DEPTH = cusr_pkg::CUSR_QDEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    output logic            o_full,
    input  cusr_pkg::t_item i_push_item,
    output logic            o_pop_valid,
    input  logic            i_pop,
    output cusr_pkg::t_item o_pop_item
);
    import cusr_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item              r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic [PTR_W-1:0]   n_wr_ptr;
    logic [PTR_W-1:0]   n_rd_ptr;
    logic [CNT_W-1:0]   n_count;
    logic               w_push;
    logic               w_pop;

    assign o_full      = (r_count == CNT_W'(DEPTH));
    assign o_pop_valid = (r_count != '0);
    assign o_pop_item  = r_mem[r_rd_ptr];
    assign w_push      = i_push_valid && !o_full;
    assign w_pop       = i_pop && o_pop_valid;

    // Advance pointers with wrap and track the fill level
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (w_push && !w_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_pop && !w_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the pushed request
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

endmodule

FILE: hdl/cusr_back.sv
// Back end: applies requests to the session state and registers the result.
// Depends on cusr_pkg.
`timescale 1ns / 1ps
module cusr_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_item_valid,
    output logic              o_pop,
    input  cusr_pkg::t_item   i_item,
    input  logic [31:0]       i_timeout_ms,
    output logic              o_valid,
    input  logic              i_stall,
    output cusr_pkg::t_result o_result
);
    import cusr_pkg::*;

    logic        r_out_valid;
    t_result     r_result;
    t_result     n_result;
    logic        r_receiving;
    logic        n_receiving;
    logic [15:0] r_current_session;
    logic [15:0] n_current_session;
    logic [15:0] r_expected_index;
    logic [15:0] n_expected_index;
    logic [31:0] r_last_activity;
    logic [31:0] n_last_activity;
    logic [31:0] w_elapsed;
    logic        w_same;
    logic        w_ack;
    logic [1:0]  w_kind;
    logic [15:0] w_chunk;
    logic [2:0]  w_status;
    logic        w_discard;
    logic        w_reboot;

    // Take a request when the output register is free or being emptied
    assign o_pop = i_item_valid && (!r_out_valid || !i_stall);

    assign w_elapsed = i_item.now_ms - r_last_activity;
    assign w_same    = r_receiving && (i_item.session_id == r_current_session);

    // Apply the request to the session state
    always_comb begin
        n_receiving       = r_receiving;
        n_current_session = r_current_session;
        n_expected_index  = r_expected_index;
        n_last_activity   = r_last_activity;
        w_ack     = 1'b0;
        w_kind    = KIND_START;
        w_chunk   = '0;
        w_status  = ST_OK;
        w_discard = 1'b0;
        w_reboot  = 1'b0;
        unique case (i_item.op)
            OP_START: begin
                if (i_item.mine) begin
                    w_ack  = 1'b1;
                    w_kind = KIND_START;
                    if (!w_same) begin
                        // Drop any open image before opening a new session
                        w_discard = r_receiving;
                        if (!i_item.storage_ok) begin
                            n_receiving = 1'b0;
                            w_status    = ST_SIZE;
                        end else begin
                            n_receiving       = 1'b1;
                            n_current_session = i_item.session_id;
                            n_expected_index  = '0;
                            n_last_activity   = i_item.now_ms;
                        end
                    end
                end
            end
            OP_CHUNK: begin
                w_ack   = 1'b1;
                w_kind  = KIND_CHUNK;
                w_chunk = i_item.chunk_index;
                if (!i_item.mine || !w_same) begin
                    w_status = ST_SESSION;
                end else begin
                    n_last_activity = i_item.now_ms;
                    if (i_item.chunk_index == r_expected_index) begin
                        if (!i_item.storage_ok) begin
                            w_status = ST_WRITE;
                        end else begin
                            n_expected_index = r_expected_index + 16'd1;
                        end
                    end else if (r_expected_index != '0 &&
                                 i_item.chunk_index == r_expected_index - 16'd1) begin
                        // Re-acknowledge a repeat of the previous chunk
                        w_status = ST_OK;
                    end else begin
                        w_status = ST_SESSION;
                    end
                end
            end
            OP_END: begin
                w_ack  = 1'b1;
                w_kind = KIND_END;
                if (!i_item.mine || !w_same || r_expected_index != i_item.total_chunks) begin
                    w_status = ST_SESSION;
                end else begin
                    n_receiving = 1'b0;
                    if (!i_item.storage_ok) begin
                        w_discard = 1'b1;
                        w_status  = ST_CHECKSUM;
                    end else begin
                        w_reboot = 1'b1;
                    end
                end
            end
            OP_ABORT: begin
                if (i_item.mine && w_same) begin
                    n_receiving = 1'b0;
                    w_discard   = 1'b1;
                end
            end
            OP_TICK: begin
                // Drop a session idle past the limit
                if (r_receiving && w_elapsed > i_timeout_ms) begin
                    n_receiving = 1'b0;
                    w_discard   = 1'b1;
                end
            end
            OP_NONE: begin
                w_ack = 1'b0;
            end
            default: begin
                w_ack = 1'b0;
            end
        endcase
    end

    // Assemble the result, zero ack fields when no ack goes out
    always_comb begin
        n_result.ack_valid      = w_ack;
        n_result.ack_kind       = w_ack ? w_kind : '0;
        n_result.ack_session    = w_ack ? n_current_session : '0;
        n_result.ack_chunk      = w_ack ? w_chunk : '0;
        n_result.ack_status     = w_ack ? w_status : '0;
        n_result.discard_image  = w_discard;
        n_result.reboot_request = w_reboot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid       <= 1'b0;
            r_receiving       <= 1'b0;
            r_current_session <= '0;
            r_expected_index  <= '0;
            r_last_activity   <= '0;
        end else begin
            if (o_pop) begin
                r_out_valid       <= 1'b1;
                r_receiving       <= n_receiving;
                r_current_session <= n_current_session;
                r_expected_index  <= n_expected_index;
                r_last_activity   <= n_last_activity;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_result;

endmodule

FILE: hdl/chunked_update_session_receiver_unit.sv
// Receiver of a stop-and-wait chunked firmware transfer. It takes one request
// per clock when nothing stalls and gives exactly one result per request, in
// order, through the front end register, the queue and the back end output
// register. This rate is set by the back end, which updates the session state
// (flag, session id, expected chunk, last activity time) as it takes each
// request. A short queue between the decoding front end and the back end lets
// each side stall on its own. Configuration: node id at byte address 0,
// timeout in ms at byte address 4; write them only while the block is idle.
// Depends on cusr_pkg, cusr_front, cusr_queue, cusr_back, assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module chunked_update_session_receiver_unit #(
    parameter int QUEUE_DEPTH = cusr_pkg::CUSR_QDEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_req_type,
    input  logic [15:0] i_target_id,
    input  logic [15:0] i_session_id,
    input  logic [15:0] i_chunk_index,
    input  logic [15:0] i_total_chunks,
    input  logic [31:0] i_now_ms,
    input  logic        i_storage_ok,
    // Result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_ack_valid,
    output logic [1:0]  o_ack_kind,
    output logic [15:0] o_ack_session,
    output logic [15:0] o_ack_chunk,
    output logic [2:0]  o_ack_status,
    output logic        o_discard_image,
    output logic        o_reboot_request,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import cusr_pkg::*;

    logic [15:0] r_node_id;
    logic [31:0] r_timeout_ms;
    logic        w_cfg_wr;
    logic        w_front_valid;
    logic        w_q_full;
    t_item       w_front_item;
    logic        w_q_valid;
    logic        w_q_pop;
    t_item       w_q_item;
    t_result     w_result;

    // Configuration registers
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_id    <= '0;
            r_timeout_ms <= CUSR_TIMEOUT_RST;
        end else if (w_cfg_wr) begin
            unique case (paddr[2])
                REG_NODE_ID: r_node_id    <= pwdata[15:0];
                REG_TIMEOUT: r_timeout_ms <= pwdata;
                default:     r_timeout_ms <= r_timeout_ms;
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (paddr[2])
            REG_NODE_ID: prdata = {16'd0, r_node_id};
            REG_TIMEOUT: prdata = r_timeout_ms;
            default:     prdata = '0;
        endcase
    end

    cusr_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_req_type     (i_req_type),
        .i_target_id    (i_target_id),
        .i_session_id   (i_session_id),
        .i_chunk_index  (i_chunk_index),
        .i_total_chunks (i_total_chunks),
        .i_now_ms       (i_now_ms),
        .i_storage_ok   (i_storage_ok),
        .i_node_id      (r_node_id),
        .o_item_valid   (w_front_valid),
        .i_item_stall   (w_q_full),
        .o_item         (w_front_item)
    );

    cusr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_front_valid),
        .o_full       (w_q_full),
        .i_push_item  (w_front_item),
        .o_pop_valid  (w_q_valid),
        .i_pop        (w_q_pop),
        .o_pop_item   (w_q_item)
    );

    cusr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (w_q_valid),
        .o_pop        (w_q_pop),
        .i_item       (w_q_item),
        .i_timeout_ms (r_timeout_ms),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_result     (w_result)
    );

    assign o_ack_valid      = w_result.ack_valid;
    assign o_ack_kind       = w_result.ack_kind;
    assign o_ack_session    = w_result.ack_session;
    assign o_ack_chunk      = w_result.ack_chunk;
    assign o_ack_status     = w_result.ack_status;
    assign o_discard_image  = w_result.discard_image;
    assign o_reboot_request = w_result.reboot_request;

    // Checks
    `CUSR_ASSERT_IMPLY(a_reboot_on_ok_end, i_clk, i_rst_n, o_valid && o_reboot_request, o_ack_valid && o_ack_status == ST_OK && o_ack_kind == KIND_END)
    `CUSR_ASSERT_IMPLY(a_quiet_fields_zero, i_clk, i_rst_n, o_valid && !o_ack_valid, o_ack_kind == '0 && o_ack_session == '0 && o_ack_chunk == '0 && o_ack_status == '0)
    `CUSR_ASSERT_NEVER(a_discard_and_reboot, i_clk, i_rst_n, o_valid && o_discard_image && o_reboot_request)

endmodule
